[design/roce_loss_injector_forwarder_top_assert.svh]
// assertion macros for the roce loss injector forwarder
`ifndef ROCE_LOSS_INJECTOR_FORWARDER_TOP_ASSERT_SVH
`define ROCE_LOSS_INJECTOR_FORWARDER_TOP_ASSERT_SVH

// cond implies prop in the same cycle
`define RLIF_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// cond implies prop in the next cycle
`define RLIF_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

// cond implies prop a fixed number of cycles later
`define RLIF_ASSERT_DELAY(label, clk, rst, cond, n, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##n (prop)) \
      else $error(msg);

`endif

[design/rlif_pkg.sv]
//------------------------------------------------------------------------------
// rlif_pkg
// item types and constants for the roce loss injector forwarder
//------------------------------------------------------------------------------
`default_nettype none

package rlif_pkg;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] frame_length;
      logic [15:0] ether_type;
      logic [7:0]  ip_protocol;
      logic [3:0]  ip_header_words;
      logic [15:0] udp_dest_port;
      logic [31:0] ip_dest_addr;
      logic [47:0] mac_addr;
      logic [31:0] random_word;
      logic [3:0]  index;
      logic        entry_valid;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [47:0] out_dest_mac;
      logic        mac_rewritten;
      logic [63:0] counter_value;
   } rsp_type;

   localparam logic [1:0] FUNC_PACKET = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;

   localparam logic [1:0] VERDICT_PASS       = 2'd0;
   localparam logic [1:0] VERDICT_DROP       = 2'd1;
   localparam logic [1:0] VERDICT_TRANSMIT   = 2'd2;
   localparam logic [1:0] VERDICT_NOT_PACKET = 2'd3;

   localparam logic [1:0] CNT_RX   = 2'd0;
   localparam logic [1:0] CNT_ROCE = 2'd1;
   localparam logic [1:0] CNT_DROP = 2'd2;
   localparam logic [1:0] CNT_TX   = 2'd3;
   localparam int         CNT_NUM  = 4;

   localparam logic [15:0] ROCE_PORT = 16'd4791;
   localparam logic [15:0] ETH_IPV4  = 16'h0800;
   localparam logic [7:0]  PROTO_UDP = 8'd17;
   localparam logic [3:0]  PLAIN_IHL = 4'd5;
   localparam logic [15:0] LEN_ETH   = 16'd14;
   localparam logic [15:0] LEN_IP    = 16'd34;
   localparam logic [15:0] LEN_UDP   = 16'd42;

   // x mod 1000000 via q = (x * ceil(2^50 / 1000000)) >> 50, exact for 32-bit x
   localparam logic [19:0] ROLL_MOD   = 20'd1000000;
   localparam logic [30:0] ROLL_RECIP = 31'd1125899907;
   localparam int          ROLL_SHIFT = 50;
   localparam int          QUOT_BITS  = 13;

   localparam int RATE_BITS = 20;

endpackage

`default_nettype wire

[design/roce_loss_injector_forwarder_top.sv]
//------------------------------------------------------------------------------
// roce_loss_injector_forwarder_top
// classifies parsed packet items, drops roce packets at a set rate, rewrites
// the destination mac from a peer table and keeps four packet counters
//------------------------------------------------------------------------------
// usage:
//   request: an item is taken at a clock edge with start high and busy low.
//     busy is high only while reset is held, so one item enters every cycle.
//   func 0 is a packet, func 1 writes a peer table slot, func 2 reads a counter.
//   response: every item gives one result on rsp_item, marked by rsp_strobe
//     for exactly one cycle, in item order, once it has passed the pipeline.
//   throughput: one item per cycle; the pipeline has four stages plus the
//     output register, split at the two multiplies of the mod 1000000 roll,
//     the peer table compare and the counter update.
//   table writes and counter reads act in item order, so an item sees the
//     effect of every item taken before it.
//   csr: csr_we with csr_wdata sets the drop rate in ppm; write it only while
//     no items are in flight.
//   reset: synchronous; clears the pipeline, the drop rate, all peer valid
//     marks and the four counters. the receiver cannot stall results.
//------------------------------------------------------------------------------
`default_nettype none

`include "roce_loss_injector_forwarder_top_assert.svh"

module roce_loss_injector_forwarder_top
   import rlif_pkg::*;
#(
   parameter int PEER_SLOTS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire req_type              req_item,
   output logic                      rsp_strobe,
   output rsp_type                   rsp_item,
   input  wire logic                 csr_we,
   input  wire logic [RATE_BITS-1:0] csr_wdata
);

   localparam int SLOT_BITS = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

   // configuration
   logic [RATE_BITS-1:0] drop_rate_ff;

   // stage 1
   logic        s1_valid_ff;
   req_type     s1_item_ff;
   logic [62:0] s1_prod;
   logic        s1_roce;

   // stage 2
   logic                 s2_valid_ff;
   req_type              s2_item_ff;
   logic                 s2_roce_ff;
   logic [QUOT_BITS-1:0] s2_quot_ff;
   logic [32:0]          s2_prod;

   // stage 3
   logic                 s3_valid_ff;
   req_type              s3_item_ff;
   logic                 s3_roce_ff;
   logic [31:0]          s3_qm_ff;
   logic [31:0]          s3_diff;
   logic [RATE_BITS-1:0] s3_rem;
   logic                 s3_drop;
   logic [PEER_SLOTS-1:0] s3_match;
   logic                 s3_hit;
   logic [SLOT_BITS-1:0] s3_sel;
   logic [8:0]           s3_index_ext;
   logic                 s3_write;

   // peer table
   logic [PEER_SLOTS-1:0] peer_valid_ff;
   logic [31:0]           peer_ip_ff [PEER_SLOTS];
   logic [47:0]           peer_mac_ff [PEER_SLOTS];

   // stage 4
   logic        s4_valid_ff;
   req_type     s4_item_ff;
   logic        s4_roce_ff;
   logic        s4_drop_ff;
   logic        s4_hit_ff;
   logic [47:0] s4_mac_ff;

   // counters and output
   logic [63:0] cnt_ff [CNT_NUM];
   logic [63:0] cnt_in [CNT_NUM];
   rsp_type     rsp_in;
   rsp_type     rsp_ff;
   logic        rsp_strobe_ff;

   assign busy = reset;

   // stage 1: classify, first multiply of the roll
   assign s1_prod = 63'(s1_item_ff.random_word) * 63'(ROLL_RECIP);
   assign s1_roce = (s1_item_ff.func == FUNC_PACKET) &&
                    (s1_item_ff.frame_length >= LEN_ETH) &&
                    (s1_item_ff.ether_type == ETH_IPV4) &&
                    (s1_item_ff.frame_length >= LEN_IP) &&
                    (s1_item_ff.ip_protocol == PROTO_UDP) &&
                    (s1_item_ff.ip_header_words == PLAIN_IHL) &&
                    (s1_item_ff.frame_length >= LEN_UDP) &&
                    (s1_item_ff.udp_dest_port == ROCE_PORT);

   // stage 2: quotient times modulus
   assign s2_prod = 33'(s2_quot_ff) * 33'(ROLL_MOD);

   // stage 3: remainder, drop roll, peer table compare and write
   assign s3_diff      = s3_item_ff.random_word - s3_qm_ff;
   assign s3_rem       = s3_diff[RATE_BITS-1:0];
   assign s3_drop      = s3_roce_ff && (drop_rate_ff != '0) && (s3_rem < drop_rate_ff);
   assign s3_index_ext = {5'd0, s3_item_ff.index};
   assign s3_write     = s3_valid_ff && (s3_item_ff.func == FUNC_WRITE) &&
                         (int'(s3_item_ff.index) < PEER_SLOTS);

   always_comb begin
      for (int s = 0; s < PEER_SLOTS; s++) begin
         s3_match[s] = peer_valid_ff[s] && (peer_ip_ff[s] == s3_item_ff.ip_dest_addr);
      end
   end

   always_comb begin
      s3_hit = 1'b0;
      s3_sel = '0;
      for (int s = PEER_SLOTS - 1; s >= 0; s--) begin
         if (s3_match[s]) begin
            s3_hit = 1'b1;
            s3_sel = SLOT_BITS'(s);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_write) begin
         peer_ip_ff[s3_index_ext[SLOT_BITS-1:0]]  <= s3_item_ff.ip_dest_addr;
         peer_mac_ff[s3_index_ext[SLOT_BITS-1:0]] <= s3_item_ff.mac_addr;
      end
      s4_mac_ff <= peer_mac_ff[s3_sel];
   end

   // stage 4: counters and result
   always_comb begin
      for (int c = 0; c < CNT_NUM; c++) begin
         cnt_in[c] = cnt_ff[c];
      end
      rsp_in = '0;
      rsp_in.verdict = VERDICT_NOT_PACKET;
      case (s4_item_ff.func)
         FUNC_PACKET: begin
            cnt_in[CNT_RX]      = cnt_ff[CNT_RX] + 64'd1;
            rsp_in.verdict      = VERDICT_PASS;
            rsp_in.out_dest_mac = s4_item_ff.mac_addr;
            if (s4_roce_ff) begin
               cnt_in[CNT_ROCE] = cnt_ff[CNT_ROCE] + 64'd1;
               if (s4_drop_ff) begin
                  cnt_in[CNT_DROP] = cnt_ff[CNT_DROP] + 64'd1;
                  rsp_in.verdict   = VERDICT_DROP;
               end else begin
                  cnt_in[CNT_TX] = cnt_ff[CNT_TX] + 64'd1;
                  rsp_in.verdict = VERDICT_TRANSMIT;
                  if (s4_hit_ff) begin
                     rsp_in.out_dest_mac  = s4_mac_ff;
                     rsp_in.mac_rewritten = 1'b1;
                  end
               end
            end
         end
         FUNC_READ: begin
            if (s4_item_ff.index < 4'(CNT_NUM)) begin
               rsp_in.counter_value = cnt_ff[s4_item_ff.index[1:0]];
            end
         end
         default: begin
            rsp_in.verdict = VERDICT_NOT_PACKET;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_rate_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         peer_valid_ff <= '0;
         for (int c = 0; c < CNT_NUM; c++) begin
            cnt_ff[c] <= '0;
         end
      end else begin
         if (csr_we) begin
            drop_rate_ff <= csr_wdata;
         end
         s1_valid_ff   <= start;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         s4_valid_ff   <= s3_valid_ff;
         rsp_strobe_ff <= s4_valid_ff;
         if (s3_write) begin
            peer_valid_ff[s3_index_ext[SLOT_BITS-1:0]] <= s3_item_ff.entry_valid;
         end
         if (s4_valid_ff) begin
            for (int c = 0; c < CNT_NUM; c++) begin
               cnt_ff[c] <= cnt_in[c];
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_item_ff <= req_item;
      s2_item_ff <= s1_item_ff;
      s2_roce_ff <= s1_roce;
      s2_quot_ff <= s1_prod[62:ROLL_SHIFT];
      s3_item_ff <= s2_item_ff;
      s3_roce_ff <= s2_roce_ff;
      s3_qm_ff   <= s2_prod[31:0];
      s4_item_ff <= s3_item_ff;
      s4_roce_ff <= s3_roce_ff;
      s4_drop_ff <= s3_drop;
      s4_hit_ff  <= s3_hit;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   `RLIF_ASSERT_DELAY(a_latency, clock, reset, start && !busy, 5, rsp_strobe,
      "item taken without a result five cycles later")
   `RLIF_ASSERT_IMPLY(a_rewrite_tx, clock, reset,
      rsp_strobe && (rsp_item.verdict != VERDICT_TRANSMIT), !rsp_item.mac_rewritten,
      "mac rewrite flagged on a result that is not transmitted")
   `RLIF_ASSERT_NEXT(a_drop_count, clock, reset,
      s4_valid_ff && (s4_item_ff.func == FUNC_PACKET) && s4_drop_ff,
      cnt_ff[CNT_DROP] == $past(cnt_ff[CNT_DROP]) + 64'd1,
      "dropped packet not counted")

endmodule

`default_nettype wire
